// ===== hdl/dspd_pkg.sv =====
// shared types and constants for the dual sync packet deframer
// no dependencies; imported by dspd_front, dspd_back and the top level
package dspd_pkg;

    localparam int unsigned CNT_W       = 5;
    localparam int unsigned STORE_DEPTH = 20;
    localparam int unsigned STORE_AW    = 5;
    localparam int unsigned RESULT_W    = 192;

    localparam logic [7:0] BALL_SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] BALL_SYNC_SECOND_RST = 8'h55;
    localparam logic [7:0] TAP_SYNC_FIRST_RST   = 8'hA5;
    localparam logic [7:0] TAP_SYNC_SECOND_RST  = 8'h5A;
    localparam logic [3:0] NIBBLE_MASK          = 4'hF;

    // configuration register indexes
    localparam logic [1:0] REG_BALL_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_BALL_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_TAP_SYNC_FIRST   = 2'd2;
    localparam logic [1:0] REG_TAP_SYNC_SECOND  = 2'd3;

    // classified input beat
    typedef struct packed {
        logic       flush;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] ball_first;
        logic [7:0] ball_second;
        logic [7:0] tap_first;
        logic [7:0] tap_second;
    } sync_cfg_t;

endpackage

// ===== hdl/dual_sync_packet_deframer_core.sv =====
// top level of the dual sync packet deframer: config registers, front queue, back parser
// depends on dspd_pkg, dspd_front and dspd_back
//
//  channel   | direction | handshake                      | payload
//  ----------+-----------+--------------------------------+----------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready  | tdata = data_byte, tuser = command
//  m_axis    | out       | m_axis_tvalid / m_axis_tready  | tdata = result fields, tuser = kind
//  cfg       | in        | cfg_valid / cfg_ready          | cfg_index, cfg_data (sync bytes)
//
// one input beat per cycle is sustained while the sink keeps up; with the queue empty, a
// frame's final byte passes through a queue entry and then the result register onto m_axis
// the parser takes a beat whenever the result register is empty or being drained,
// so a stalled sink stops the parser and the queue fills before s_axis_tready drops
// rst_n clears phase, held byte, count, xor, queue pointers and restores the sync bytes;
// cfg is always ready and should only be written while the block is idle
module dual_sync_packet_deframer_core
    import dspd_pkg::*;
#(
    parameter int unsigned BALL_FRAME_LEN = 20,
    parameter int unsigned TAP_FRAME_LEN  = 9
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
    input  logic                s_axis_tuser,   // [0] command (1 = flush)
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [15:0] ball_x, [31:16] ball_y, [47:32] last_x, [63:48] last_y,
    // [79:64] field_width, [95:80] field_height, [127:96] speed_bits,
    // [135:128] possession_code, [143:136] score_pair,
    // [159:144] tap_side_slot, [191:160] tap_uid
    output logic [RESULT_W-1:0] m_axis_tdata,
    output logic                m_axis_tuser,   // [0] frame_kind (1 = tap frame)
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    // the frame store needs no clearing since every entry read was written in the same frame
    sync_cfg_t sync_cfg_reg;
    logic      item_valid;
    item_t     item;
    logic      item_pop;

    assign cfg_ready = 1'b1;

    // sync byte registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_cfg_reg.ball_first  <= BALL_SYNC_FIRST_RST;
            sync_cfg_reg.ball_second <= BALL_SYNC_SECOND_RST;
            sync_cfg_reg.tap_first   <= TAP_SYNC_FIRST_RST;
            sync_cfg_reg.tap_second  <= TAP_SYNC_SECOND_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BALL_SYNC_FIRST:  sync_cfg_reg.ball_first  <= cfg_data;
                REG_BALL_SYNC_SECOND: sync_cfg_reg.ball_second <= cfg_data;
                REG_TAP_SYNC_FIRST:   sync_cfg_reg.tap_first   <= cfg_data;
                REG_TAP_SYNC_SECOND:  sync_cfg_reg.tap_second  <= cfg_data;
                default:              sync_cfg_reg <= sync_cfg_reg;
            endcase
        end
    end

    // front: classify each beat and queue it
    dspd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (s_axis_tuser),
        .in_byte    (s_axis_tdata),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    // back: hunt, gather, check and hold the result
    dspd_back #(
        .BALL_FRAME_LEN (BALL_FRAME_LEN),
        .TAP_FRAME_LEN  (TAP_FRAME_LEN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .sync_cfg   (sync_cfg_reg),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res_kind   (m_axis_tuser),
        .res_data   (m_axis_tdata)
    );

endmodule

// ===== hdl/dspd_front.sv =====
// front end: accepts input beats, classifies them and queues them
// depends on dspd_pkg (item_t)
module dspd_front
    import dspd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       in_cmd,
    input  logic [7:0] in_byte,
    output logic       item_valid,
    output item_t      item,
    input  logic       item_pop
);

    item_t      queue_mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    item_t      new_item;

    assign in_ready   = (count_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign item_valid = (count_reg != 2'd0);
    assign pop        = item_pop && item_valid;
    assign item       = queue_mem[rd_ptr_reg];

    always_comb
    begin
        new_item.flush     = in_cmd;
        new_item.data_byte = in_byte;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ===== hdl/dspd_back.sv =====
// back end: sync hunt, frame gathering, tap checksum and result register
// depends on dspd_pkg (item_t, sync_cfg_t, store constants)
module dspd_back
    import dspd_pkg::*;
#(
    parameter int unsigned BALL_FRAME_LEN = 20,
    parameter int unsigned TAP_FRAME_LEN  = 9
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  sync_cfg_t           sync_cfg,
    input  logic                item_valid,
    input  item_t               item,
    output logic                item_pop,
    output logic                res_valid,
    input  logic                res_ready,
    output logic                res_kind,
    output logic [RESULT_W-1:0] res_data
);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_BALL = 2'd1,
        PH_TAP  = 2'd2
    } phase_t;

    localparam logic [CNT_W-1:0] BALL_LAST = CNT_W'(BALL_FRAME_LEN - 1);
    localparam logic [CNT_W-1:0] TAP_LAST  = CNT_W'(TAP_FRAME_LEN - 1);

    phase_t              phase_reg, phase_next;
    logic                held_valid_reg, held_valid_next;
    logic [7:0]          held_reg, held_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [7:0]          xor_reg, xor_next;
    logic [7:0]          store_reg  [STORE_DEPTH];
    logic [7:0]          store_next [STORE_DEPTH];
    logic                out_valid_reg, out_valid_next;
    logic                out_kind_reg, out_kind_next;
    logic [RESULT_W-1:0] out_data_reg, out_data_next;
    logic                out_free;
    logic [7:0]          b;
    logic                ball_hit;
    logic                tap_hit;
    logic [RESULT_W-1:0] ball_word;
    logic [RESULT_W-1:0] tap_word;

    assign out_free  = !out_valid_reg || res_ready;
    assign item_pop  = item_valid && out_free;
    assign b         = item.data_byte;
    assign ball_hit  = held_valid_reg && (held_reg == sync_cfg.ball_first)
                       && (b == sync_cfg.ball_second);
    assign tap_hit   = held_valid_reg && (held_reg == sync_cfg.tap_first)
                       && (b == sync_cfg.tap_second);
    assign res_valid = out_valid_reg;
    assign res_kind  = out_kind_reg;
    assign res_data  = out_data_reg;

    // result words from the store with this beat's write applied
    // fields from the lowest bit: ball_x, ball_y, last_x, last_y, field_width,
    // field_height, speed_bits, possession_code, score_pair, tap_side_slot, tap_uid
    assign ball_word = {32'd0, 16'd0,
                        store_next[19][7:4] & NIBBLE_MASK, store_next[19][3:0] & NIBBLE_MASK,
                        store_next[18],
                        store_next[17], store_next[16], store_next[15], store_next[14],
                        store_next[12], store_next[13],
                        store_next[10], store_next[11],
                        store_next[8],  store_next[9],
                        store_next[6],  store_next[7],
                        store_next[4],  store_next[5],
                        store_next[2],  store_next[3]};
    assign tap_word  = {store_next[4], store_next[5], store_next[6], store_next[7],
                        store_next[2], store_next[3], 144'd0};

    always_comb
    begin
        phase_next      = phase_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        cnt_next        = cnt_reg;
        xor_next        = xor_reg;
        store_next      = store_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        out_kind_next   = out_kind_reg;
        out_data_next   = out_data_reg;

        if (item_pop)
        begin
            if (item.flush)
            begin
                phase_next      = PH_HUNT;
                held_valid_next = 1'b0;
                held_next       = 8'd0;
                cnt_next        = '0;
                xor_next        = 8'd0;
            end
            else
            begin
                case (phase_reg)
                    PH_BALL, PH_TAP:
                    begin
                        if (cnt_reg < CNT_W'(STORE_DEPTH))
                        begin
                            store_next[cnt_reg[STORE_AW-1:0]] = b;
                        end
                        if (phase_reg == PH_TAP && cnt_reg >= CNT_W'(2)
                            && cnt_reg <= CNT_W'(7))
                        begin
                            xor_next = xor_reg ^ b;
                        end
                        cnt_next = cnt_reg + CNT_W'(1);
                        if ((phase_reg == PH_BALL && cnt_reg >= BALL_LAST)
                            || (phase_reg == PH_TAP && cnt_reg >= TAP_LAST))
                        begin
                            if (phase_reg == PH_BALL)
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = 1'b0;
                                out_data_next  = ball_word;
                            end
                            else if (xor_next == store_next[8])
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = 1'b1;
                                out_data_next  = tap_word;
                            end
                            phase_next      = PH_HUNT;
                            held_valid_next = 1'b0;
                            held_next       = 8'd0;
                            cnt_next        = '0;
                            xor_next        = 8'd0;
                        end
                    end
                    default:
                    begin
                        if (ball_hit || tap_hit)
                        begin
                            store_next[0]   = held_reg;
                            store_next[1]   = b;
                            cnt_next        = CNT_W'(2);
                            xor_next        = 8'd0;
                            held_valid_next = 1'b0;
                            phase_next      = ball_hit ? PH_BALL : PH_TAP;
                        end
                        else
                        begin
                            phase_next      = PH_HUNT;
                            held_next       = b;
                            held_valid_next = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            held_valid_reg <= 1'b0;
            held_reg       <= 8'd0;
            cnt_reg        <= '0;
            xor_reg        <= 8'd0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            held_valid_reg <= held_valid_next;
            held_reg       <= held_next;
            cnt_reg        <= cnt_next;
            xor_reg        <= xor_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg    <= store_next;
        out_data_reg <= out_data_next;
    end

endmodule
